### rtl/icga_pkg.sv
// Shared widths, limits and controller/datapath interface types for the admit unit.
`default_nettype none
package icga_pkg;
	localparam int STOP_W = 11;
	localparam int AMT_W = 16;
	localparam int CAP_W = 16;
	localparam int SUM_W = 26;
	localparam logic [SUM_W-1:0] SUM_MAX = 26'h3FFFFFF;
	localparam logic [CAP_W-1:0] CAP_RESET = 16'd100;
	localparam int MAX_STOPS_DEF = 2048;
	localparam int MAX_REQUESTS_DEF = 1024;

	typedef struct packed {
		logic load;
		logic clr;
		logic scan;
		logic walk_init;
		logic peak;
		logic room;
		logic add;
		logic sum;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scan_done;
		logic found;
		logic walk_done;
	} sts_t;
endpackage
`default_nettype wire

### rtl/icga_ctrl.sv
// Controller state machine sequencing load, clear, select, peak and add passes.
`default_nettype none
module icga_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic last_request,
	input wire icga_pkg::sts_t sts,
	output icga_pkg::cmd_t cmd,
	output logic busy
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR = 4'd1;
	localparam logic [3:0] ST_SCAN = 4'd2;
	localparam logic [3:0] ST_WINIT = 4'd3;
	localparam logic [3:0] ST_PEAK = 4'd4;
	localparam logic [3:0] ST_ROOM = 4'd5;
	localparam logic [3:0] ST_ADD = 4'd6;
	localparam logic [3:0] ST_SUM = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_request) state_d = ST_CLR;
				end
			end
			ST_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = sts.found ? ST_WINIT : ST_DONE;
			end
			ST_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d = ST_PEAK;
			end
			ST_PEAK: begin
				cmd.peak = 1'b1;
				if (sts.walk_done) state_d = ST_ROOM;
			end
			ST_ROOM: begin
				cmd.room = 1'b1;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add = 1'b1;
				if (sts.walk_done) state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SCAN;
			end
			ST_DONE: begin
				cmd.done = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

### rtl/icga_dpath.sv
// Datapath: request store, stop load memory, selection, peak, add and total.
`default_nettype none
module icga_dpath #(
	parameter int MAX_STOPS = icga_pkg::MAX_STOPS_DEF,
	parameter int MAX_REQUESTS = icga_pkg::MAX_REQUESTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire icga_pkg::cmd_t cmd,
	output icga_pkg::sts_t sts,
	input wire logic [icga_pkg::STOP_W-1:0] source_stop,
	input wire logic [icga_pkg::STOP_W-1:0] destination_stop,
	input wire logic [icga_pkg::AMT_W-1:0] amount,
	input wire logic [icga_pkg::CAP_W-1:0] cap,
	output logic done,
	output logic [icga_pkg::SUM_W-1:0] total_admitted
);
	localparam int SW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int EW = (SW + 1 > icga_pkg::STOP_W) ? SW + 1 : icga_pkg::STOP_W;
	localparam int RW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CW = $clog2(MAX_REQUESTS + 1);
	localparam int KW = icga_pkg::STOP_W + RW;
	localparam int EW_ = icga_pkg::STOP_W;
	localparam int DW = 2 * EW_ + icga_pkg::AMT_W;
	localparam logic [EW-1:0] STOPS_E = EW'(MAX_STOPS);
	localparam logic [EW-1:0] STOPS_LAST = EW'(MAX_STOPS - 1);
	localparam logic [CW-1:0] REQS_C = CW'(MAX_REQUESTS);

	logic [DW-1:0] req_mem [MAX_REQUESTS];
	logic [icga_pkg::CAP_W-1:0] load_mem [MAX_STOPS];

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] scan_j_q;
	logic rv_s1;
	logic [RW-1:0] ridx_s1;
	logic [DW-1:0] rdata_s1;
	logic prev_valid_q, best_valid_q;
	logic [KW-1:0] prev_key_q, best_key_q;
	logic [EW_-1:0] best_src_q, best_dst_q;
	logic [icga_pkg::AMT_W-1:0] best_amt_q;
	logic [EW-1:0] k_q, end_q;
	logic v_s1;
	logic [SW-1:0] a_s1;
	logic [icga_pkg::CAP_W-1:0] ldata_s1;
	logic [icga_pkg::CAP_W-1:0] peak_q, take_q;
	logic [icga_pkg::SUM_W-1:0] sum_q;
	logic done_q;

	logic scan_issue, walk_issue;
	logic [KW-1:0] cand_key;
	logic cand_ok;
	logic [EW-1:0] dst_e, src_e;
	logic [icga_pkg::CAP_W-1:0] room;
	logic [icga_pkg::CAP_W:0] add_v;
	logic [icga_pkg::CAP_W-1:0] add_sat;
	logic [icga_pkg::SUM_W:0] sum_v;

	assign scan_issue = cmd.scan && (scan_j_q < cnt_q);
	assign walk_issue = (cmd.peak || cmd.add) && (k_q < end_q);
	assign cand_key = {rdata_s1[DW-1 -: EW_], ridx_s1};
	assign cand_ok = rv_s1 && (!prev_valid_q || cand_key > prev_key_q)
		&& (!best_valid_q || cand_key < best_key_q);
	assign dst_e = EW'(best_dst_q);
	assign src_e = EW'(best_src_q);
	assign room = (peak_q >= cap) ? '0 : cap - peak_q;
	assign add_v = {1'b0, ldata_s1} + {1'b0, take_q};
	assign add_sat = (add_v > {1'b0, cap}) ? cap : add_v[icga_pkg::CAP_W-1:0];
	assign sum_v = {1'b0, sum_q} + (icga_pkg::SUM_W+1)'(take_q);

	assign sts.clr_last = (k_q == STOPS_LAST);
	assign sts.scan_done = (scan_j_q >= cnt_q) && !rv_s1;
	assign sts.found = best_valid_q;
	assign sts.walk_done = (k_q >= end_q) && !v_s1;

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (cmd.load && cnt_q < REQS_C)
			req_mem[cnt_q[RW-1:0]] <= {destination_stop, source_stop, amount};
		rdata_s1 <= req_mem[scan_j_q[RW-1:0]];
		if (cmd.clr) load_mem[k_q[SW-1:0]] <= '0;
		else if (cmd.add && v_s1) load_mem[a_s1] <= add_sat;
		ldata_s1 <= load_mem[k_q[SW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rv_s1 <= 1'b0;
			v_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (cmd.load && cnt_q < REQS_C) cnt_q <= cnt_q + 1'b1;
			if (cmd.done) cnt_q <= '0;
			rv_s1 <= scan_issue;
			v_s1 <= walk_issue;
			done_q <= cmd.done;
		end
	end

	always_ff @(posedge clk) begin
		ridx_s1 <= scan_j_q[RW-1:0];
		a_s1 <= k_q[SW-1:0];
		if (cmd.load) k_q <= '0;
		if (cmd.clr) begin
			k_q <= k_q + 1'b1;
			sum_q <= '0;
			prev_valid_q <= 1'b0;
		end
		if (cmd.clr || cmd.sum) begin
			scan_j_q <= '0;
			best_valid_q <= 1'b0;
		end
		if (scan_issue) scan_j_q <= scan_j_q + 1'b1;
		if (cand_ok) begin
			best_valid_q <= 1'b1;
			best_key_q <= cand_key;
			best_dst_q <= rdata_s1[DW-1 -: EW_];
			best_src_q <= rdata_s1[icga_pkg::AMT_W +: EW_];
			best_amt_q <= rdata_s1[icga_pkg::AMT_W-1:0];
		end
		if (cmd.walk_init) begin
			k_q <= src_e;
			end_q <= (dst_e > STOPS_E) ? STOPS_E : dst_e;
			peak_q <= '0;
		end
		if (walk_issue) k_q <= k_q + 1'b1;
		if (cmd.peak && v_s1 && ldata_s1 > peak_q) peak_q <= ldata_s1;
		if (cmd.room) begin
			take_q <= (best_amt_q < room) ? best_amt_q : room;
			k_q <= src_e;
		end
		if (cmd.sum) begin
			sum_q <= (sum_v > {1'b0, icga_pkg::SUM_MAX}) ? icga_pkg::SUM_MAX
				: sum_v[icga_pkg::SUM_W-1:0];
			prev_valid_q <= 1'b1;
			prev_key_q <= best_key_q;
		end
		if (cmd.done) total_admitted <= sum_q;
	end

	assign done = done_q;
endmodule
`default_nettype wire

### rtl/interval_capacity_greedy_admit_unit.sv
// Top level of the greedy interval capacity admit unit.
//
//   channel   | handshake               | payload
//   ----------+-------------------------+----------------------------------------------
//   request   | start, busy             | source_stop, destination_stop, amount, last_request
//   config    | cfg_wr_en               | cfg_wr_data (truck capacity)
//   result    | done (one-cycle strobe) | total_admitted
//
// A request item is taken while the unit is idle; the item marked last starts the batch.
// The stop loads are then cleared one stop at a time. Each of the n stored requests
// then costs a selection scan, a peak walk and an add walk over its stop range,
// and the walk-init, room and sum steps. A scan that finds nothing and the done
// state end the batch, and the total strobe follows. Reset idles the controller,
// empties the store and sets the capacity to 100; the receiver cannot stall results.
`default_nettype none
module interval_capacity_greedy_admit_unit #(
	parameter int MAX_STOPS = icga_pkg::MAX_STOPS_DEF,
	parameter int MAX_REQUESTS = icga_pkg::MAX_REQUESTS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [icga_pkg::STOP_W-1:0] source_stop,
	input wire logic [icga_pkg::STOP_W-1:0] destination_stop,
	input wire logic [icga_pkg::AMT_W-1:0] amount,
	input wire logic last_request,
	input wire logic cfg_wr_en,
	input wire logic [icga_pkg::CAP_W-1:0] cfg_wr_data,
	output logic done,
	output logic [icga_pkg::SUM_W-1:0] total_admitted
);
	icga_pkg::cmd_t cmd;
	icga_pkg::sts_t sts;
	logic [icga_pkg::CAP_W-1:0] cap_q;
	logic go;

	// The capacity register; the host must write it only while the unit is idle, which the block does not enforce.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= icga_pkg::CAP_RESET;
		else if (cfg_wr_en) cap_q <= cfg_wr_data;
	end

	// A request item is accepted only while the controller is idle.
	assign go = start && !busy;

	icga_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(go),
		.last_request(last_request),
		.sts(sts),
		.cmd(cmd),
		.busy(busy)
	);

	icga_dpath #(
		.MAX_STOPS(MAX_STOPS),
		.MAX_REQUESTS(MAX_REQUESTS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.source_stop(source_stop),
		.destination_stop(destination_stop),
		.amount(amount),
		.cap(cap_q),
		.done(done),
		.total_admitted(total_admitted)
	);
endmodule
`default_nettype wire

### rtl/icga_checker.sv
// Port-level checker for the admit unit and its bind.
`default_nettype none
module icga_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic last_request,
	input wire logic done
);
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_last_starts: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_request |=> busy) else $error("batch did not start");
	a_plain_load: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !last_request |=> !busy) else $error("busy after plain item");
endmodule

bind interval_capacity_greedy_admit_unit icga_checker u_icga_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.last_request(last_request),
	.done(done)
);
`default_nettype wire
